/* rtl/block_liveness_marker_assert.svh */
// Assertion macros used by the liveness marker top level.
`ifndef BLOCK_LIVENESS_MARKER_ASSERT_SVH
`define BLOCK_LIVENESS_MARKER_ASSERT_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define BLM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("block_liveness_marker: same-cycle check failed");

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define BLM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("block_liveness_marker: next-cycle check failed");

`endif

/* rtl/blm_pkg.sv */
// Shared types, constants and helpers of the liveness marker.
package blm_pkg;

  // Size of the flag store and the width of its index.
  localparam int NUM_VALUES = 256;
  localparam int IDX_W      = $clog2(NUM_VALUES);
  localparam int ID_W       = 8;

  // Request codes.
  localparam logic [1:0] REQ_ANALYZE = 2'd0;
  localparam logic [1:0] REQ_RESTORE = 2'd1;
  localparam logic [1:0] REQ_SEED    = 2'd2;

  // Operand slots, visited in this order.
  localparam logic [1:0] SLOT_DEST = 2'd0;
  localparam logic [1:0] SLOT_SRC1 = 2'd1;
  localparam logic [1:0] SLOT_SRC2 = 2'd2;
  localparam int         NUM_SLOTS = 3;

  // Flags kept for one value id.
  typedef struct packed {
    logic live;
    logic used;
  } flags_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       cap_en;
    logic [1:0] cap_sel;
    logic       wr_en;
    logic [1:0] wr_sel;
    logic       result;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic start_analyze;
    logic item_analyze;
  } status_t;

  // An id addresses the store only when it lies below its size.
  function automatic logic id_in_range(input logic [ID_W-1:0] id);
    return 32'(id) < NUM_VALUES;
  endfunction

endpackage

/* rtl/blm_ctrl.sv */
// Controller sequencing the read and write phases of one item.
module blm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  blm_pkg::status_t  status,
  output blm_pkg::cmd_t     cmd,
  output logic              busy,
  output logic              result_strobe
);
  import blm_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;

  localparam logic [1:0] LAST_READ  = 2'd3;
  localparam logic [1:0] LAST_WRITE = SLOT_SRC2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [1:0] cnt;
  logic [1:0] cnt_next;
  logic       result_strobe_next;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          cnt_next = 2'd0;
          state_next = status.start_analyze ? S_READ : S_WRITE;
        end
      end
      S_READ: begin
        // Reads issue on counts 0 to 2; the registered data of the previous slot is captured on counts 1 to 3.
        cmd.rd_en   = (cnt != LAST_READ);
        cmd.rd_sel  = cnt;
        cmd.cap_en  = (cnt != 2'd0);
        cmd.cap_sel = cnt - 2'd1;
        if (cnt == LAST_READ) begin
          cnt_next   = 2'd0;
          state_next = S_WRITE;
        end else begin
          cnt_next = cnt + 2'd1;
        end
      end
      S_WRITE: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = cnt;
        cmd.result = (cnt == SLOT_DEST) && status.item_analyze;
        if (cnt == LAST_WRITE) begin
          cnt_next   = 2'd0;
          state_next = S_IDLE;
        end else begin
          cnt_next = cnt + 2'd1;
        end
      end
      default: begin
        state_next = S_IDLE;
        cnt_next   = 2'd0;
      end
    endcase
  end

  assign result_strobe_next = cmd.result;
  assign busy = (state != S_IDLE);

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cnt           <= 2'd0;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      cnt           <= cnt_next;
      result_strobe <= result_strobe_next;
    end
  end

endmodule

/* rtl/blm_dp.sv */
// Datapath: item registers, flag store and update logic.
module blm_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  blm_pkg::cmd_t              cmd,
  output blm_pkg::status_t           status,
  input  logic [1:0]                 req_type,
  input  logic                       is_nop,
  input  logic [blm_pkg::ID_W-1:0]   dest_id,
  input  logic                       dest_present,
  input  logic                       dest_is_source,
  input  logic                       dest_temporary,
  input  logic [blm_pkg::ID_W-1:0]   src1_id,
  input  logic                       src1_present,
  input  logic                       src1_temporary,
  input  logic [blm_pkg::ID_W-1:0]   src2_id,
  input  logic                       src2_present,
  input  logic                       src2_temporary,
  output logic                       dest_live_out,
  output logic                       dest_next_use_out,
  output logic                       src1_live_out,
  output logic                       src1_next_use_out,
  output logic                       src2_live_out,
  output logic                       src2_next_use_out,
  output logic                       discard
);
  import blm_pkg::*;

  // Latched item.
  logic [1:0]      req;
  logic            nop;
  logic            d_src;
  logic [ID_W-1:0] ids  [NUM_SLOTS];
  logic            pres [NUM_SLOTS];
  logic            tmp  [NUM_SLOTS];

  // Flag store with one read and one write port; valid bits give the reset value.
  flags_t                flag_mem [NUM_VALUES];
  logic [NUM_VALUES-1:0] valid;
  flags_t                rd_flags;
  logic                  rd_ok;

  flags_t          old_flags [NUM_SLOTS];
  logic            rng       [NUM_SLOTS];
  logic            wen       [NUM_SLOTS];
  flags_t          wval      [NUM_SLOTS];
  logic            disc;
  logic            is_analyze;
  logic            is_restore;
  logic            is_seed;
  logic            wr_go;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] wr_idx;
  flags_t          cap_val;

  // Capture the item on acceptance.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req             <= req_type;
      nop             <= is_nop;
      d_src           <= dest_is_source;
      ids[SLOT_DEST]  <= dest_id;
      ids[SLOT_SRC1]  <= src1_id;
      ids[SLOT_SRC2]  <= src2_id;
      pres[SLOT_DEST] <= dest_present;
      pres[SLOT_SRC1] <= src1_present;
      pres[SLOT_SRC2] <= src2_present;
      tmp[SLOT_DEST]  <= dest_temporary;
      tmp[SLOT_SRC1]  <= src1_temporary;
      tmp[SLOT_SRC2]  <= src2_temporary;
    end
  end

  assign is_analyze = (req == REQ_ANALYZE);
  assign is_restore = (req == REQ_RESTORE);
  assign is_seed    = (req == REQ_SEED);

  assign status.start_analyze = (req_type == REQ_ANALYZE);
  assign status.item_analyze  = is_analyze;

  always_comb begin
    for (int k = 0; k < NUM_SLOTS; k++) begin
      rng[k] = id_in_range(ids[k]);
    end
  end

  // Store read port, data registered.
  assign rd_idx = IDX_W'(ids[cmd.rd_sel]);

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_flags <= flag_mem[rd_idx];
      rd_ok    <= valid[rd_idx];
    end
  end

  // Old flags of a slot read as zero when absent, out of range, never written or in a nop item.
  assign cap_val = (pres[cmd.cap_sel] && !nop && rng[cmd.cap_sel] && rd_ok) ? rd_flags : '0;

  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      old_flags[cmd.cap_sel] <= cap_val;
    end
  end

  // In an analyze item, a written destination that is not also a source and is neither live nor used later is dead.
  assign disc = is_analyze && !nop && pres[SLOT_DEST] && !d_src &&
                !old_flags[SLOT_DEST].live && !old_flags[SLOT_DEST].used;

  // Per-slot write decision and value.
  always_comb begin
    wen[SLOT_DEST] = is_seed ? !tmp[SLOT_DEST] :
                     is_restore ? (pres[SLOT_DEST] && !tmp[SLOT_DEST]) :
                     is_analyze ? (!nop && !disc && pres[SLOT_DEST]) : 1'b0;
    wval[SLOT_DEST].live = is_analyze ? d_src : 1'b1;
    wval[SLOT_DEST].used = is_analyze ? d_src : 1'b0;
    for (int k = 1; k < NUM_SLOTS; k++) begin
      wen[k] = is_restore ? (pres[k] && !tmp[k]) :
               is_analyze ? (!nop && !disc && pres[k]) : 1'b0;
      wval[k].live = 1'b1;
      wval[k].used = is_analyze;
    end
  end

  // Store write port.
  assign wr_go  = cmd.wr_en && wen[cmd.wr_sel] && rng[cmd.wr_sel];
  assign wr_idx = IDX_W'(ids[cmd.wr_sel]);

  always_ff @(posedge clk) begin
    if (wr_go) begin
      flag_mem[wr_idx] <= wval[cmd.wr_sel];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_go) begin
      valid[wr_idx] <= 1'b1;
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.result) begin
      dest_live_out     <= old_flags[SLOT_DEST].live;
      dest_next_use_out <= old_flags[SLOT_DEST].used;
      src1_live_out     <= old_flags[SLOT_SRC1].live;
      src1_next_use_out <= old_flags[SLOT_SRC1].used;
      src2_live_out     <= old_flags[SLOT_SRC2].live;
      src2_next_use_out <= old_flags[SLOT_SRC2].used;
      discard           <= disc;
    end
  end

endmodule

/* rtl/block_liveness_marker.sv */
// An analyze item reads the old flags of its slots one by one, then writes the new flags;
// restore and seed items only write. The flag store's single read port and single
// write port make the slots go one after another; a new item is taken only when idle.
// Restore and seed give no result; the receiver cannot stall the result strobe.
// Reset (rst, synchronous) clears the controller and all valid bits of the flag
// store, so every value reads as not live and not used afterwards.
`include "block_liveness_marker_assert.svh"

module block_liveness_marker (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               req_type,
  input  logic                     is_nop,
  input  logic [blm_pkg::ID_W-1:0] dest_id,
  input  logic                     dest_present,
  input  logic                     dest_is_source,
  input  logic                     dest_temporary,
  input  logic [blm_pkg::ID_W-1:0] src1_id,
  input  logic                     src1_present,
  input  logic                     src1_temporary,
  input  logic [blm_pkg::ID_W-1:0] src2_id,
  input  logic                     src2_present,
  input  logic                     src2_temporary,
  output logic                     result_strobe,
  output logic                     dest_live_out,
  output logic                     dest_next_use_out,
  output logic                     src1_live_out,
  output logic                     src1_next_use_out,
  output logic                     src2_live_out,
  output logic                     src2_next_use_out,
  output logic                     discard
);
  import blm_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer.
  blm_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .status        (status),
    .cmd           (cmd),
    .busy          (busy),
    .result_strobe (result_strobe)
  );

  // Flag store and update logic.
  blm_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .req_type          (req_type),
    .is_nop            (is_nop),
    .dest_id           (dest_id),
    .dest_present      (dest_present),
    .dest_is_source    (dest_is_source),
    .dest_temporary    (dest_temporary),
    .src1_id           (src1_id),
    .src1_present      (src1_present),
    .src1_temporary    (src1_temporary),
    .src2_id           (src2_id),
    .src2_present      (src2_present),
    .src2_temporary    (src2_temporary),
    .dest_live_out     (dest_live_out),
    .dest_next_use_out (dest_next_use_out),
    .src1_live_out     (src1_live_out),
    .src1_next_use_out (src1_next_use_out),
    .src2_live_out     (src2_live_out),
    .src2_next_use_out (src2_next_use_out),
    .discard           (discard)
  );

  // A result only appears while an item is still being worked on.
  `BLM_ASSERT_NOW(a_strobe_busy, result_strobe, busy)
  // An accepted item keeps the block busy in the next cycle.
  `BLM_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // Each item gives at most a single-cycle result strobe.
  `BLM_ASSERT_NEXT(a_strobe_single, result_strobe, !result_strobe)
  // A discarded instruction had a destination with both flags clear.
  `BLM_ASSERT_NOW(a_discard_dead, result_strobe && discard, !dest_live_out && !dest_next_use_out)

endmodule
